FILE: rtl/core/interval_arithmetic_unit_assert.svh
// Assertion macros for the interval arithmetic unit.
// Each use expects clk and arst_n in scope.
`ifndef INTERVAL_ARITHMETIC_UNIT_ASSERT_SVH
`define INTERVAL_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication.
`define IAU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("interval unit check failed");

// Next-cycle implication.
`define IAU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("interval unit check failed");

`endif

FILE: rtl/core/iau_pkg.sv
package iau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_e_t;

	localparam logic CFG_ROUND_EN  = 1'b0;
	localparam logic CFG_ROUND_POS = 1'b1;

	localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

	// Data that rides alongside the divider lanes.
	typedef struct packed {
		op_e_t            op;
		logic             flag;
		logic [63:0]      lo;
		logic [63:0]      hi;
		logic [3:0][63:0] p;
	} side_t;

endpackage

FILE: rtl/core/iau_shift.sv
module iau_shift #(
	parameter int W = 32
) (
	input  logic [W-1:0] value,
	input  logic [5:0]   shift,
	input  logic         round_en,
	input  logic         round_pos,
	output logic [W-1:0] result
);

	logic signed [W-1:0] v;
	logic signed [W-1:0] vr;
	logic [4:0]          rn;
	logic [5:0]          ln;
	logic [63:0]         c;
	logic [63:0]         sum;

	assign v = $signed(value);

	always_comb begin
		rn  = shift[4:0];
		ln  = 6'd0 - shift;
		// half an LSB, one less for negative values unless positive rounding
		c   = (64'd1 << (rn - 5'd1)) - {63'd0, v[W-1] & ~round_pos};
		sum = {{(64-W){v[W-1]}}, v} + c;
		vr  = round_en ? $signed(sum[W-1:0]) : v;
		if (value == '0 || shift == 6'd0) begin
			result = value;
		end else if (!shift[5]) begin
			result = vr >>> rn;
		end else begin
			result = value << ln;
		end
	end

endmodule

FILE: rtl/core/iau_div.sv
module iau_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         adv,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W:0]   quotient,
	output logic         neg
);

	localparam int N = W + 1;

	logic [N-1:0] num_s [0:N];
	logic [N-1:0] rem_s [0:N];
	logic [N-1:0] den_s [0:N];
	logic         neg_s [0:N];

	logic [N-1:0] a_ext;
	logic [N-1:0] b_ext;

	assign a_ext = {a[W-1], a};
	assign b_ext = {b[W-1], b};

	// take magnitudes, quotient sign travels alongside
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s[0] <= a[W-1] ? (N'(0) - a_ext) : a_ext;
			den_s[0] <= b[W-1] ? (N'(0) - b_ext) : b_ext;
			rem_s[0] <= '0;
			neg_s[0] <= a[W-1] ^ b[W-1];
		end
	end

	// one restoring step per stage
	for (genvar k = 1; k <= N; k++) begin : g_step
		logic [N:0] trial;
		logic [N:0] diff;
		logic       ge;

		assign trial = {rem_s[k-1], num_s[k-1][N-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= ge ? diff[N-1:0] : trial[N-1:0];
				num_s[k] <= {num_s[k-1][N-2:0], ge};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	assign quotient = num_s[N];
	assign neg      = neg_s[N];

endmodule

FILE: rtl/core/interval_arithmetic_unit.sv
// Interval arithmetic unit: takes two operand intervals with pending shifts and
// returns the result interval of add, subtract, multiply or divide, one beat in
// and one beat out per cycle when neither side stalls. The depth is set by the
// divider, four restoring-division lanes of VALUE_WIDTH + 1 one-bit steps plus
// a magnitude stage, with shift, product/sum, a quotient sign stage and two
// min/max stages around it. A two-entry output (last stage plus skid register)
// catches a result when the sink stalls, and the input stops while the skid
// register is full. The user must write Rounding and round_positive through the
// cfg port only while the unit is idle; the block itself does not enforce this.
module interval_arithmetic_unit
	import iau_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_addr,
	input  logic         cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// a_min, a_max, a_shift, a_size, b_min, b_max, b_shift, b_size, result_size
	input  logic [159:0] s_tdata,
	// op
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// res_min, res_max
	output logic [127:0] m_tdata,
	// div_zero_possible
	output logic         m_tuser
);

	`include "interval_arithmetic_unit_assert.svh"

	localparam int W       = VALUE_WIDTH;
	localparam int DIV_LAT = VALUE_WIDTH + 2;

	function automatic logic [W-1:0] sext_size(logic [W-1:0] v, logic [5:0] size);
		logic [5:0] k;
		k = 6'(W) - size;
		if (size == 6'd0 || size >= 6'(W)) begin
			return v;
		end
		return $signed(v << k) >>> k;
	endfunction

	function automatic logic [63:0] sx(logic [W-1:0] v);
		return {{(64-W){v[W-1]}}, v};
	endfunction

	// configuration registers
	logic rounding_enable_q;
	logic round_positive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounding_enable_q <= 1'b0;
			round_positive_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_ROUND_EN:  rounding_enable_q <= cfg_wdata;
				CFG_ROUND_POS: round_positive_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// whole pipeline moves together; only a full skid register stops it
	logic adv;
	logic skid_v_q;
	assign adv      = !skid_v_q;
	assign s_tready = adv;

	// stage 1: apply pending shifts
	logic [W-1:0] sh_amin, sh_amax, sh_bmin, sh_bmax;

	iau_shift #(.W(W)) u_sh_amin (.value(s_tdata[W-1:0]), .shift(s_tdata[69:64]),
		.round_en(rounding_enable_q), .round_pos(round_positive_q), .result(sh_amin));
	iau_shift #(.W(W)) u_sh_amax (.value(s_tdata[32+W-1:32]), .shift(s_tdata[69:64]),
		.round_en(rounding_enable_q), .round_pos(round_positive_q), .result(sh_amax));
	iau_shift #(.W(W)) u_sh_bmin (.value(s_tdata[76+W-1:76]), .shift(s_tdata[145:140]),
		.round_en(rounding_enable_q), .round_pos(round_positive_q), .result(sh_bmin));
	iau_shift #(.W(W)) u_sh_bmax (.value(s_tdata[108+W-1:108]), .shift(s_tdata[145:140]),
		.round_en(rounding_enable_q), .round_pos(round_positive_q), .result(sh_bmax));

	logic         v_s1;
	logic [W-1:0] amin_s1, amax_s1, bmin_s1, bmax_s1;
	op_e_t        op_s1;
	logic [5:0]   asize_s1, bsize_s1;
	logic [6:0]   rsize_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			amin_s1  <= sh_amin;
			amax_s1  <= sh_amax;
			bmin_s1  <= sh_bmin;
			bmax_s1  <= sh_bmax;
			op_s1    <= op_e_t'(s_tuser);
			asize_s1 <= s_tdata[75:70];
			bsize_s1 <= s_tdata[151:146];
			rsize_s1 <= s_tdata[158:152];
		end
	end

	// stage 2: sums, products, divisor test, divider operands
	logic [W-1:0] da_min, da_max, db_min, db_max;
	logic         zero_hit;
	logic [6:0]   rs_eff;
	logic [63:0]  sat_hi;
	side_t        side_c;

	always_comb begin
		da_min   = sext_size(amin_s1, asize_s1);
		da_max   = sext_size(amax_s1, asize_s1);
		db_min   = sext_size(bmin_s1, bsize_s1);
		db_max   = sext_size(bmax_s1, bsize_s1);
		zero_hit = db_min == '0 || db_max == '0
			|| ($signed(db_max) > 0 && $signed(db_min) < 0);
		rs_eff   = (rsize_s1 == 7'd0 || rsize_s1 > 7'd64) ? 7'd64 : rsize_s1;
		sat_hi   = POS_LIMIT >> (7'd64 - rs_eff);

		side_c.op   = op_s1;
		side_c.flag = op_s1 == OP_DIV && zero_hit;
		side_c.p[0] = 64'($signed(amax_s1) * $signed(bmax_s1));
		side_c.p[1] = 64'($signed(amax_s1) * $signed(bmin_s1));
		side_c.p[2] = 64'($signed(amin_s1) * $signed(bmax_s1));
		side_c.p[3] = 64'($signed(amin_s1) * $signed(bmin_s1));
		case (op_s1)
			OP_ADD: begin
				side_c.lo = sx(amin_s1) + sx(bmin_s1);
				side_c.hi = sx(amax_s1) + sx(bmax_s1);
			end
			OP_SUB: begin
				side_c.lo = sx(amin_s1) - sx(bmax_s1);
				side_c.hi = sx(amax_s1) - sx(bmin_s1);
			end
			default: begin
				side_c.lo = ~sat_hi;
				side_c.hi = sat_hi;
			end
		endcase
	end

	logic             v_s2;
	side_t            side_s2;
	logic [3:0][W-1:0] na_s2, nb_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2  <= side_c;
			na_s2[0] <= da_max;
			nb_s2[0] <= db_max;
			na_s2[1] <= da_max;
			nb_s2[1] <= db_min;
			na_s2[2] <= da_min;
			nb_s2[2] <= db_max;
			na_s2[3] <= da_min;
			nb_s2[3] <= db_min;
		end
	end

	// divider lanes in parallel with the side line
	logic [3:0][W:0] qmag;
	logic [3:0]      qneg;

	for (genvar l = 0; l < 4; l++) begin : g_lane
		iau_div #(.W(W)) u_div (
			.clk      (clk),
			.adv      (adv),
			.a        (na_s2[l]),
			.b        (nb_s2[l]),
			.quotient (qmag[l]),
			.neg      (qneg[l])
		);
	end

	side_t side_sd [0:DIV_LAT-1];
	logic  v_sd    [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sd[0] <= side_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				side_sd[i] <= side_sd[i-1];
			end
		end
	end

	// stage 4: sign the quotients, pick the candidate set
	logic             v_s4;
	side_t            side_s4;
	logic [3:0][63:0] x_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_sd[DIV_LAT-1];
			for (int l = 0; l < 4; l++) begin
				if (side_sd[DIV_LAT-1].op == OP_MUL) begin
					x_s4[l] <= side_sd[DIV_LAT-1].p[l];
				end else if (qneg[l]) begin
					x_s4[l] <= 64'd0 - {{(63-W){1'b0}}, qmag[l]};
				end else begin
					x_s4[l] <= {{(63-W){1'b0}}, qmag[l]};
				end
			end
		end
	end

	// stage 5: pairwise min and max
	logic        v_s5;
	side_t       side_s5;
	logic [63:0] lo01_s5, hi01_s5, lo23_s5, hi23_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			lo01_s5 <= ($signed(x_s4[1]) < $signed(x_s4[0])) ? x_s4[1] : x_s4[0];
			hi01_s5 <= ($signed(x_s4[1]) > $signed(x_s4[0])) ? x_s4[1] : x_s4[0];
			lo23_s5 <= ($signed(x_s4[3]) < $signed(x_s4[2])) ? x_s4[3] : x_s4[2];
			hi23_s5 <= ($signed(x_s4[3]) > $signed(x_s4[2])) ? x_s4[3] : x_s4[2];
		end
	end

	// stage 6: final min and max, select by operation
	logic        v_s6;
	logic [63:0] min_s6, max_s6;
	logic        flag_s6;
	logic        use_set;

	assign use_set = side_s5.op == OP_MUL || (side_s5.op == OP_DIV && !side_s5.flag);

	always_ff @(posedge clk) begin
		if (adv) begin
			flag_s6 <= side_s5.flag;
			if (use_set) begin
				min_s6 <= ($signed(lo23_s5) < $signed(lo01_s5)) ? lo23_s5 : lo01_s5;
				max_s6 <= ($signed(hi23_s5) > $signed(hi01_s5)) ? hi23_s5 : hi01_s5;
			end else begin
				min_s6 <= side_s5.lo;
				max_s6 <= side_s5.hi;
			end
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				v_sd[i] <= 1'b0;
			end
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1    <= s_tvalid;
			v_s2    <= v_s1;
			v_sd[0] <= v_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				v_sd[i] <= v_sd[i-1];
			end
			v_s4 <= v_sd[DIV_LAT-1];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// skid register: catch the last stage when the sink stalls
	logic [63:0] skid_min_q, skid_max_q;
	logic        skid_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_s6 && !m_tready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_min_q  <= min_s6;
			skid_max_q  <= max_s6;
			skid_flag_q <= flag_s6;
		end
	end

	assign m_tvalid = skid_v_q || v_s6;
	assign m_tdata  = skid_v_q ? {skid_max_q, skid_min_q} : {max_s6, min_s6};
	assign m_tuser  = skid_v_q ? skid_flag_q : flag_s6;

	// saturated divide results are always [-(m+1), m]
	`IAU_ASSERT_IMP(a_sat_shape, m_tvalid && m_tuser, m_tdata[127:64] == ~m_tdata[63:0])
	// a held result in the skid register is never dropped while the sink stalls
	`IAU_ASSERT_NXT(a_skid_hold, skid_v_q && !m_tready, skid_v_q)
	// a stalled pipeline keeps its last stage
	`IAU_ASSERT_NXT(a_tail_hold, !adv, $stable(v_s6) && $stable(min_s6) && $stable(max_s6))

endmodule
